@@ rtl/core/fir_window_filter_top_assert.svh @@
// Assertion macros used by the filter top level.
`ifndef FIR_WINDOW_FILTER_TOP_ASSERT_SVH
`define FIR_WINDOW_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FWF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FWF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fwf_pkg.sv @@
// Types and constants of the windowed FIR filter.
`default_nettype none
package fwf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = 38;
    localparam int OUT_W     = 24;
    localparam int FRAC_BITS = 14;
    localparam int TAP_W     = 3;
    localparam int CFG_IDX_W = 4;
    localparam int COEF_REGS = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST = 4'd7;

    // Reset values
    localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 3'd3;
    localparam logic signed [COEF_W-1:0] COEF_RESET [COEF_REGS] = '{
        18'sd4096, 18'sd8192, 18'sd4096, 18'sd0, 18'sd0, 18'sd0, 18'sd0
    };

    // Rounding and saturation bounds at accumulator width
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 38'sd8192;
    localparam logic signed [ACC_W-1:0] SAT_HI     = 38'sd8388607;
    localparam logic signed [ACC_W-1:0] SAT_LO     = -38'sd8388608;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic advance;
        logic clear;
    } t_cell_ctrl;

    // Status of the sum and output stages
    typedef struct packed {
        logic sum_vld;
        logic hold;
    } t_out_status;

endpackage
`default_nettype wire

@@ rtl/core/fir_window_filter_top.sv @@
// Top level of the windowed FIR filter: config registers, the cell chain and the output stage.
`default_nettype none
`include "fir_window_filter_top_assert.svh"

// Transposed-form FIR over signed 16-bit samples built as a chain of
// MAX_TAPS cells. The filter accepts one sample per clock while o_in_stall
// is low and returns one result per sample; a result is registered in the
// cells and then passes through round and saturate into the output
// register. Each cell holds one partial sum and does one 18x16
// multiply-add per sample, which sets the clock-rate limit; the output
// register and the sum stage together let a new sample enter while a result
// still waits. The result is tapped at cell tap_count-1 (tap_count of 0 acts
// as 1, above MAX_TAPS acts as MAX_TAPS). Any write to a listed register
// clears the history; writes to other indexes are ignored. Configure only
// while idle.
module fir_window_filter_top
    import fwf_pkg::*;
#(
    parameter int MAX_TAPS = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample requests
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [SAMPLE_W-1:0]  i_sample_in,
    // result requests
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [OUT_W-1:0]     o_filtered,
    output logic                        o_clipped,
    // configuration write requests
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COEF_W-1:0]           i_cfg_data
);

    localparam int SEL_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam logic [TAP_W-1:0] TAP_MAX = TAP_W'(MAX_TAPS);

    logic [TAP_W-1:0]         r_tap_count;
    logic [TAP_W-1:0]         n_tap_count;
    logic signed [COEF_W-1:0] r_coef [MAX_TAPS];
    logic signed [COEF_W-1:0] n_coef [MAX_TAPS];

    logic                     w_cfg_clear;
    logic                     w_in_accept;
    t_cell_ctrl               w_ctrl;
    t_out_status              w_status;
    logic [TAP_W-1:0]         w_taps;
    logic [TAP_W-1:0]         w_sel_full;
    logic [SEL_W-1:0]         w_sel;
    logic signed [ACC_W-1:0]  w_acc [MAX_TAPS];
    logic signed [ACC_W-1:0]  w_tap;

    assign o_cfg_ready = 1'b1;

    // Any listed register write clears the history
    assign w_cfg_clear = i_cfg_valid && (i_cfg_index inside {[CFG_TAP_COUNT:CFG_COEF_LAST]});

    // Update configuration registers
    always_comb begin
        n_tap_count = r_tap_count;
        for (int k = 0; k < MAX_TAPS; k++) begin
            n_coef[k] = r_coef[k];
        end
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TAP_COUNT) begin
                n_tap_count = i_cfg_data[TAP_W-1:0];
            end
            for (int k = 0; k < MAX_TAPS; k++) begin
                if (i_cfg_index == CFG_COEF_BASE + CFG_IDX_W'(k)) begin
                    n_coef[k] = i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RESET;
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_coef[k] <= COEF_RESET[k];
            end
        end else begin
            r_tap_count <= n_tap_count;
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_coef[k] <= n_coef[k];
            end
        end
    end

    // Advance the chain on each accepted sample
    assign w_in_accept    = i_in_valid && !w_status.hold;
    assign o_in_stall     = w_status.hold;
    assign w_ctrl.advance = w_in_accept;
    assign w_ctrl.clear   = w_cfg_clear;

    // Cell k carries coef k; the oldest-sample cell starts from zero
    for (genvar p = 0; p < MAX_TAPS; p++) begin : g_cell
        logic signed [ACC_W-1:0] w_acc_in;
        if (p == 0) begin : g_head
            assign w_acc_in = '0;
        end else begin : g_link
            assign w_acc_in = w_acc[p-1];
        end
        fwf_tap_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_sample (i_sample_in),
            .i_coef   (r_coef[p]),
            .i_acc    (w_acc_in),
            .o_acc    (w_acc[p])
        );
    end

    // Clamp the tap count and pick the finished sum
    always_comb begin
        w_taps = r_tap_count;
        if (r_tap_count == '0) begin
            w_taps = TAP_W'(1);
        end else if (r_tap_count > TAP_MAX) begin
            w_taps = TAP_MAX;
        end
    end
    assign w_sel_full = w_taps - TAP_W'(1);
    assign w_sel      = w_sel_full[SEL_W-1:0];
    assign w_tap      = w_acc[w_sel];

    fwf_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_in_accept),
        .i_sum       (w_tap),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_filtered  (o_filtered),
        .o_clipped   (o_clipped)
    );

    `FWF_ASSERT_IMP(a_stall_when_full, o_in_stall, o_out_valid && i_out_stall && w_status.sum_vld, "input stalled without both stages full")
    `FWF_ASSERT_NXT(a_accept_fills_sum, w_in_accept, w_status.sum_vld, "accepted sample left no pending sum")
    `FWF_ASSERT_NXT(a_cfg_clears_chain, w_cfg_clear, w_acc[MAX_TAPS-1] == ACC_W'(0), "history not cleared after config write")

endmodule
`default_nettype wire

@@ rtl/core/fwf_tap_cell.sv @@
// One cell of the transposed FIR chain: multiply-add into a partial sum.
`default_nettype none
module fwf_tap_cell
    import fwf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctrl                 i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [COEF_W-1:0]   i_coef,
    input  logic signed [ACC_W-1:0]    i_acc,
    output logic signed [ACC_W-1:0]    o_acc
);

    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    // Weight the incoming sample
    assign w_prod = i_coef * i_sample;

    // Add to the neighbor's partial sum, or drop the history on clear
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.advance) begin
            n_acc = ACC_W'(w_prod) + i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

@@ rtl/core/fwf_out_stage.sv @@
// Sum stage control plus round, saturate and output register.
`default_nettype none
module fwf_out_stage
    import fwf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic signed [ACC_W-1:0]  i_sum,
    input  logic                     i_out_stall,
    output t_out_status              o_status,
    output logic                     o_out_valid,
    output logic signed [OUT_W-1:0]  o_filtered,
    output logic                     o_clipped
);

    logic                    r_sum_vld;
    logic                    n_sum_vld;
    logic                    r_out_vld;
    logic                    n_out_vld;
    logic signed [OUT_W-1:0] r_filtered;
    logic                    r_clipped;
    logic                    w_move;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [ACC_W-1:0] w_q;
    logic signed [OUT_W-1:0] w_sat;
    logic                    w_clip;

    // Move the pending sum into the output register when it is free
    assign w_move = r_sum_vld && (!r_out_vld || !i_out_stall);

    assign o_status.sum_vld = r_sum_vld;
    assign o_status.hold    = r_sum_vld && r_out_vld && i_out_stall;

    // Round half up, then floor shift
    assign w_rnd = i_sum + ROUND_HALF;
    assign w_q   = w_rnd >>> FRAC_BITS;

    // Saturate to the output range
    always_comb begin
        w_clip = 1'b0;
        w_sat  = OUT_W'(w_q);
        if (w_q > SAT_HI) begin
            w_sat  = OUT_W'(SAT_HI);
            w_clip = 1'b1;
        end else if (w_q < SAT_LO) begin
            w_sat  = OUT_W'(SAT_LO);
            w_clip = 1'b1;
        end
    end

    // Track occupancy of both stages
    always_comb begin
        n_sum_vld = r_sum_vld;
        if (i_load) begin
            n_sum_vld = 1'b1;
        end else if (w_move) begin
            n_sum_vld = 1'b0;
        end
        n_out_vld = w_move || (r_out_vld && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_sum_vld <= n_sum_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Hold the result payload until it moves on
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_filtered <= w_sat;
            r_clipped  <= w_clip;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_filtered  = r_filtered;
    assign o_clipped   = r_clipped;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the windowed FIR filter with a built-in filter predictor.
module testbench
    import fwf_pkg::*;
();

    localparam int MAX_TAPS = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_COEF_LAST + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = '1;
    localparam int RANDOM_PHASES = 8;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    clipped;
    } t_output;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [COEF_W-1:0]          data;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       typed;
        logic signed [OUT_W-1:0]    want;
    } t_stim_row;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    // Directed sequence: typed outputs where they follow directly, else predicted
    localparam int DIRECTED_ROWS = 43;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // reset taps 0.25 / 0.5 / 0.25 on a full-scale step
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h7FFF, 1'b1, 24'sd8192},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h7FFF, 1'b1, 24'sd24575},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h7FFF, 1'b1, 24'sd32767},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h8000, 1'b1, 24'sd16383},
        // single tap at the coefficient extremes
        '{ROW_WRITE,  CFG_TAP_COUNT, 18'd1, 16'h0, 1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_COEF_BASE, 18'h20000, 16'h0, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h8000, 1'b1, 24'sd262144},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h7FFF, 1'b1, -24'sd262136},
        '{ROW_WRITE,  CFG_COEF_BASE, 18'h1FFFF, 16'h0, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h8000, 1'b1, -24'sd262142},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h7FFF, 1'b1, 24'sd262134},
        // rounding half up around one LSB of the output
        '{ROW_WRITE,  CFG_COEF_BASE, 18'd1, 16'h0, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h2000, 1'b1, 24'sd1},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h1FFF, 1'b1, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'hE000, 1'b1, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'hDFFF, 1'b1, -24'sd1},
        // tap count of zero acts as one tap
        '{ROW_WRITE,  CFG_TAP_COUNT, 18'd0, 16'h0, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h4000, 1'b1, 24'sd1},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h3039, 1'b0, 24'sd0},
        // a listed write clears history, an unlisted one leaves it
        '{ROW_WRITE,  CFG_TAP_COUNT, 18'd2, 16'h0, 1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_COEF_BASE, 18'd16384, 16'h0, 1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_COEF_BASE + 4'd1, 18'd0, 16'h0, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'd100, 1'b1, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'd7, 1'b1, 24'sd100},
        '{ROW_WRITE,  CFG_UNUSED_FIRST, 18'h3FFFF, 16'h0, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'd0, 1'b1, 24'sd7},
        '{ROW_WRITE,  CFG_UNUSED_LAST, 18'h2AAAA, 16'h0, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'd0, 1'b1, 24'sd0},
        // all seven taps with mixed extreme weights
        '{ROW_WRITE,  CFG_TAP_COUNT, 18'd7, 16'h0, 1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_COEF_BASE + 4'd1, 18'h1FFFF, 16'h0, 1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_COEF_BASE + 4'd2, 18'h20000, 16'h0, 1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_COEF_BASE + 4'd3, 18'd16384, 16'h0, 1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_COEF_BASE + 4'd4, 18'h3FFFF, 16'h0, 1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_COEF_BASE + 4'd5, 18'd0, 16'h0, 1'b0, 24'sd0},
        '{ROW_WRITE,  CFG_COEF_LAST, 18'd12345, 16'h0, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h8000, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h7FFF, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h8000, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h7FFF, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h0001, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'hFFFF, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h0000, 1'b0, 24'sd0},
        '{ROW_SAMPLE, CFG_TAP_COUNT, 18'h0, 16'h7FFF, 1'b0, 24'sd0}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [OUT_W-1:0]    o_filtered;
    logic                       o_clipped;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [COEF_W-1:0]          i_cfg_data = '0;

    // Filter predictor state
    logic [TAP_W-1:0]           pred_taps;
    logic signed [COEF_W-1:0]   pred_coef [COEF_REGS];
    logic signed [SAMPLE_W-1:0] pred_history [MAX_TAPS];

    t_output pending_outputs [$];
    t_output oldest_output;
    int      mismatches = 0;
    int      burst_left = 0;

    fir_window_filter_top #(.MAX_TAPS(MAX_TAPS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered),
        .o_clipped   (o_clipped),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20-unit clock period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bound the run in case the block hangs
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic reset_filter_model();
        pred_taps = 3'd3;
        pred_coef[0] = 18'sd4096;
        pred_coef[1] = 18'sd8192;
        pred_coef[2] = 18'sd4096;
        for (int k = 3; k < COEF_REGS; k++) pred_coef[k] = '0;
        for (int k = 0; k < MAX_TAPS; k++) pred_history[k] = '0;
    endtask

    // Apply a register write; listed registers clear the history
    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        if (idx == CFG_TAP_COUNT) begin
            pred_taps = data[TAP_W-1:0];
        end else if (idx >= CFG_COEF_BASE && idx <= CFG_COEF_LAST) begin
            pred_coef[idx - CFG_COEF_BASE] = data;
        end else begin
            return;
        end
        for (int k = 0; k < MAX_TAPS; k++) pred_history[k] = '0;
    endtask

    // Shift a sample in and compute the rounded, saturated output
    task automatic shift_and_filter(input logic signed [SAMPLE_W-1:0] s, output t_output r);
        int     n;
        int     k;
        longint acc;
        longint y;
        n = int'(pred_taps);
        if (n < 1) n = 1;
        if (n > MAX_TAPS) n = MAX_TAPS;
        for (k = MAX_TAPS - 1; k > 0; k--) pred_history[k] = pred_history[k-1];
        pred_history[0] = s;
        acc = 0;
        for (k = 0; k < n; k++)
            acc += longint'(pred_coef[k]) * longint'(pred_history[n-1-k]);
        y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        r.clipped = 1'b0;
        // Unreachable at these widths, kept for completeness
        if (y > 64'sd8388607) begin
            y = 64'sd8388607;
            r.clipped = 1'b1;
        end else if (y < -64'sd8388608) begin
            y = -64'sd8388608;
            r.clipped = 1'b1;
        end
        r.filtered = y[OUT_W-1:0];
    endtask

    // Drain outstanding results and lower the sample request before a write
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        apply_reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender bursts: hold the request low for a random gap between bursts
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic typed,
                               input logic signed [OUT_W-1:0] want);
        t_output pred;
        pace_sender();
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        shift_and_filter(s, pred);
        if (typed) begin
            pred.filtered = want;
            pred.clipped  = 1'b0;
        end
        pending_outputs.push_back(pred);
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        logic [COEF_W-1:0] c;
        c = COEF_W'($urandom);
        case ($urandom_range(0, 7))
            0: c = 18'h20000;
            1: c = 18'h1FFFF;
            2: c = '0;
            3: c = 18'd16384;
            4, 5: ;
            default: c = COEF_W'($signed($urandom_range(0, 8192)) - 4096);
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic signed [SAMPLE_W-1:0] s;
        s = SAMPLE_W'($urandom);
        case ($urandom_range(0, 9))
            0: s = 16'h8000;
            1: s = 16'h7FFF;
            2, 3: s = SAMPLE_W'($signed($urandom_range(0, 512)) - 256);
            default: ;
        endcase
        return s;
    endfunction

    // Receiver stall pattern: stretches of no, light, heavy or periodic stall
    initial begin
        t_stall_mode mode;
        int          span;
        int          step;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(4, 60);
            for (step = 0; step < span; step++) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:     i_out_stall <= 1'b0;
                    STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: i_out_stall <= (step % 3 != 0);
                    default:        i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected result filtered=%0d clipped=%0b",
                                          o_filtered, o_clipped));
            end else begin
                oldest_output = pending_outputs.pop_front();
                if (o_filtered !== oldest_output.filtered)
                    report_mismatch($sformatf("filtered got %0d, want %0d",
                                              o_filtered, oldest_output.filtered));
                if (o_clipped !== oldest_output.clipped)
                    report_mismatch($sformatf("clipped got %0b, want %0b",
                                              o_clipped, oldest_output.clipped));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain
    initial begin
        logic [COEF_W-1:0] wdata;
        logic [TAP_W-1:0]  taps;
        int                count;
        reset_filter_model();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            end else begin
                send_sample(DIRECTED[r].sample, DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        // Random phases, each under a fresh configuration
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            for (int c = 0; c < COEF_REGS; c++)
                write_reg(CFG_COEF_BASE + CFG_IDX_W'(c), rand_coef());
            case (phase)
                0: taps = 3'd7;
                1: taps = 3'd1;
                2: taps = 3'd0;
                default: taps = TAP_W'($urandom_range(0, 7));
            endcase
            wdata = COEF_W'($urandom);
            wdata[TAP_W-1:0] = taps;
            write_reg(CFG_TAP_COUNT, wdata);
            count = $urandom_range(80, 120);
            for (int i = 0; i < count; i++) begin
                // Occasionally poke an unlisted index; history must survive
                if ($urandom_range(0, 39) == 0) begin
                    wait_idle();
                    write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                              COEF_W'($urandom));
                end
                send_sample(rand_sample(), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ fir_window_filter_top.f @@
+incdir+rtl/core
rtl/core/fwf_pkg.sv
rtl/core/fwf_tap_cell.sv
rtl/core/fwf_out_stage.sv
rtl/core/fir_window_filter_top.sv
tb/testbench.sv
